/* rtl/core/cdeq_pkg.sv */
// ----------------------------------------------------------------------------
// cdeq_pkg
// Shared types and constants for the circular double-ended queue.
// ----------------------------------------------------------------------------
package cdeq_pkg;

  localparam int DEPTH  = 16;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = 5;
  localparam int DATA_W = 32;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
  localparam logic signed [DATA_W-1:0] NEG_ONE = '1;

  typedef logic [2:0] mode_t;

  localparam mode_t MODE_PUSH_FRONT = 3'd0;
  localparam mode_t MODE_PUSH_REAR  = 3'd1;
  localparam mode_t MODE_POP_FRONT  = 3'd2;
  localparam mode_t MODE_POP_REAR   = 3'd3;
  localparam mode_t MODE_PEEK_FRONT = 3'd4;
  localparam mode_t MODE_PEEK_REAR  = 3'd5;

  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic signed [DATA_W-1:0] word_t;

  function automatic idx_t idx_inc(input idx_t i);
    idx_t r;
    r = (i == IDX_LAST) ? '0 : i + idx_t'(1);
    return r;
  endfunction

  function automatic idx_t idx_dec(input idx_t i);
    idx_t r;
    r = (i == '0) ? IDX_LAST : i - idx_t'(1);
    return r;
  endfunction

endpackage

/* rtl/core/cdeq_if.sv */
// ----------------------------------------------------------------------------
// cdeq_if
// Valid/ready channels for operation beats and result beats.
// ----------------------------------------------------------------------------
interface cdeq_in_if;
  import cdeq_pkg::*;

  logic  valid;
  logic  ready;
  mode_t mode;
  word_t data_in;

  modport source (output valid, output mode, output data_in, input ready);
  modport sink   (input valid, input mode, input data_in, output ready);
endinterface

interface cdeq_out_if;
  import cdeq_pkg::*;

  logic  valid;
  logic  ready;
  word_t value_out;
  logic  ok;
  logic  now_empty;
  logic  now_full;
  cnt_t  occupancy;

  modport source (output valid, output value_out, output ok, output now_empty,
                  output now_full, output occupancy, input ready);
  modport sink   (input valid, input value_out, input ok, input now_empty,
                  input now_full, input occupancy, output ready);
endinterface

/* rtl/core/circular_double_ended_queue_unit.sv */
// ----------------------------------------------------------------------------
// circular_double_ended_queue_unit
// Double-ended queue in a ring memory with head, tail and count registers.
// ----------------------------------------------------------------------------
// One operation beat is taken per cycle while results keep draining; each
// result passes through the ring memory's registered read and then the
// output register. Head, tail and count update at the accept edge, so
// back-to-back beats see each other's effects with no stall. A stalled
// output holds one result plus one in flight before in_chan.ready drops.
module circular_double_ended_queue_unit (
  input  logic       clk,
  input  logic       rst_n,
  cdeq_in_if.sink    in_chan,
  cdeq_out_if.source out_chan
);
  import cdeq_pkg::*;

  word_t ring_mem [DEPTH];

  idx_t  head_r, head_nxt;
  idx_t  tail_r, tail_nxt;
  cnt_t  cnt_r, cnt_nxt;

  logic  job_vld_r;
  logic  job_rd_r;
  logic  job_ok_r;
  cnt_t  job_cnt_r;
  word_t rd_data_r;

  logic  out_valid_r;
  word_t out_value_r;
  logic  out_ok_r;
  cnt_t  out_cnt_r;

  logic  accept;
  logic  out_free;
  logic  wr_en;
  idx_t  wr_addr;
  logic  rd_en;
  idx_t  rd_addr;
  logic  op_ok;

  assign out_free      = !out_valid_r || out_chan.ready;
  assign in_chan.ready = !job_vld_r || out_free;
  assign accept        = in_chan.valid && in_chan.ready;

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt  = cnt_r;
    wr_en    = 1'b0;
    wr_addr  = '0;
    rd_en    = 1'b0;
    rd_addr  = head_r;
    op_ok    = 1'b0;
    case (in_chan.mode)
      MODE_PUSH_FRONT, MODE_PUSH_REAR: begin
        if (cnt_r != CNT_FULL) begin
          op_ok   = 1'b1;
          wr_en   = 1'b1;
          cnt_nxt = cnt_r + cnt_t'(1);
          if (cnt_r == '0) begin
            head_nxt = '0;
            tail_nxt = '0;
            wr_addr  = '0;
          end else if (in_chan.mode == MODE_PUSH_FRONT) begin
            head_nxt = idx_dec(head_r);
            wr_addr  = head_nxt;
          end else begin
            tail_nxt = idx_inc(tail_r);
            wr_addr  = tail_nxt;
          end
        end
      end
      MODE_POP_FRONT, MODE_POP_REAR: begin
        if (cnt_r != '0) begin
          op_ok   = 1'b1;
          rd_en   = 1'b1;
          rd_addr = (in_chan.mode == MODE_POP_FRONT) ? head_r : tail_r;
          if (cnt_r == cnt_t'(1)) begin
            head_nxt = '0;
            tail_nxt = '0;
            cnt_nxt  = '0;
          end else begin
            if (in_chan.mode == MODE_POP_FRONT) begin
              head_nxt = idx_inc(head_r);
            end else begin
              tail_nxt = idx_dec(tail_r);
            end
            cnt_nxt = cnt_r - cnt_t'(1);
          end
        end
      end
      MODE_PEEK_FRONT, MODE_PEEK_REAR: begin
        if (cnt_r != '0) begin
          op_ok   = 1'b1;
          rd_en   = 1'b1;
          rd_addr = (in_chan.mode == MODE_PEEK_FRONT) ? head_r : tail_r;
        end
      end
      default: begin
      end
    endcase
  end

  // ring memory: one write or one registered read per beat
  always_ff @(posedge clk) begin
    if (accept && wr_en) begin
      ring_mem[wr_addr] <= in_chan.data_in;
    end
    if (accept && rd_en) begin
      rd_data_r <= ring_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      cnt_r       <= '0;
      job_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        head_r <= head_nxt;
        tail_r <= tail_nxt;
        cnt_r  <= cnt_nxt;
      end
      if (accept) begin
        job_vld_r <= 1'b1;
      end else if (out_free) begin
        job_vld_r <= 1'b0;
      end
      if (out_free) begin
        out_valid_r <= job_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job_rd_r  <= rd_en;
      job_ok_r  <= op_ok;
      job_cnt_r <= cnt_nxt;
    end
    if (out_free && job_vld_r) begin
      out_value_r <= job_rd_r ? rd_data_r : NEG_ONE;
      out_ok_r    <= job_ok_r;
      out_cnt_r   <= job_cnt_r;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.value_out = out_value_r;
  assign out_chan.ok        = out_ok_r;
  assign out_chan.now_empty = (out_cnt_r == '0);
  assign out_chan.now_full  = (out_cnt_r == CNT_FULL);
  assign out_chan.occupancy = out_cnt_r;

endmodule
